// ===== hw/rtl/tpd_pkg.sv =====
// shared types and constants of the touch pad press detector
package tpd_pkg;

    localparam logic [3:0]  CALIB_LAST     = 4'd9;
    localparam logic [2:0]  SCAN_SHORT     = 3'd3;
    localparam logic [2:0]  SCAN_LONG      = 3'd6;
    localparam logic [1:0]  LOCKOUT_RELOAD = 2'd3;
    localparam logic [15:0] GATE_RESET     = 16'd100;

    localparam logic REG_GATE = 1'b0;
    localparam logic REG_MODE = 1'b1;

    localparam logic CMD_CALIB = 1'b0;
    localparam logic CMD_SCAN  = 1'b1;

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_CALC  = 6'b000010,
        S_DIV   = 6'b000100,
        S_JUDGE = 6'b001000,
        S_EMIT  = 6'b010000,
        S_SPARE = 6'b100000
    } t_state;

    typedef struct packed {
        logic accept;
        logic calc;
        logic div_step;
        logic judge;
        logic emit;
    } t_cmd;

    typedef struct packed {
        logic calib_last;
        logic scan_last;
        logic out_free;
    } t_status;

endpackage

// ===== hw/rtl/tpd_regs.sv =====
// configuration registers behind the apb-style port
module tpd_regs (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output logic [15:0] o_gate_margin,
    output logic        o_continuous_mode
);
    import tpd_pkg::*;

    logic [15:0] r_gate;
    logic        r_mode;
    logic        wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gate <= GATE_RESET;
            r_mode <= 1'b0;
        end else if (wr_en) begin
            if (paddr[2] == REG_MODE) begin
                r_mode <= pwdata[0];
            end else begin
                r_gate <= pwdata[15:0];
            end
        end
    end

    assign prdata = (paddr[2] == REG_MODE) ? {31'd0, r_mode} : {16'd0, r_gate};

    assign o_gate_margin     = r_gate;
    assign o_continuous_mode = r_mode;

    // paddr[1:0] only select bytes, unused for word registers
    logic unused_addr;
    assign unused_addr = ^paddr[1:0];

endmodule

// ===== hw/rtl/tpd_ctrl.sv =====
// controller state machine: sequences accept, baseline divide, scan judge and result
module tpd_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_cmd,
    input  tpd_pkg::t_status  i_status,
    output logic              o_in_stall,
    output tpd_pkg::t_cmd     o_cmd
);
    import tpd_pkg::*;

    t_state r_state, n_state;
    logic   take;

    assign take = (r_state == S_IDLE) && i_in_valid;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (take) begin
                    if (i_cmd == CMD_CALIB && i_status.calib_last) begin
                        n_state = S_CALC;
                    end else if (i_cmd == CMD_SCAN && i_status.scan_last) begin
                        n_state = S_JUDGE;
                    end
                end
            end
            S_CALC:  n_state = S_DIV;
            S_DIV:   n_state = S_EMIT;
            S_JUDGE: n_state = S_EMIT;
            S_EMIT: begin
                if (i_status.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_stall      = (r_state != S_IDLE);
    assign o_cmd.accept    = take;
    assign o_cmd.calc      = (r_state == S_CALC);
    assign o_cmd.div_step  = (r_state == S_DIV);
    assign o_cmd.judge     = (r_state == S_JUDGE);
    assign o_cmd.emit      = (r_state == S_EMIT);

endmodule

// ===== hw/rtl/tpd_datapath.sv =====
// datapath: calibration tracking, divide by six, scan maximum, lockout, result register
module tpd_datapath #(
    parameter int SAMPLE_BITS = 16
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  tpd_pkg::t_cmd          i_cmd_ctl,
    output tpd_pkg::t_status       o_status,
    input  logic                   i_cmd,
    input  logic [SAMPLE_BITS-1:0] i_sample,
    input  logic [15:0]            i_gate_margin,
    input  logic                   i_continuous_mode,
    output logic                   o_out_valid,
    input  logic                   i_out_stall,
    output logic                   o_kind,
    output logic                   o_pressed,
    output logic [SAMPLE_BITS-1:0] o_baseline
);
    import tpd_pkg::*;

    localparam int SB  = SAMPLE_BITS;
    localparam int SUMW = SB + 4;            // sum of ten samples
    localparam int DW  = SB + 3;             // sum of six samples
    localparam int YW  = DW - 1;             // half of the six-sample sum
    localparam int KW  = SB + 3;             // reciprocal scale, 2**KW / 3
    localparam int GW  = ((SB > 16) ? SB : 16) + 1;
    localparam int TW  = SB + 4;             // ten times baseline

    localparam logic [SB-1:0] ONES = {SB{1'b1}};

    // rounded-up reciprocal of three, exact for every half sum below 2**(SB+2)
    localparam longint unsigned RECIP_WIDE = ((64'd1 << KW) + 64'd2) / 64'd3;
    localparam logic [YW-1:0]   RECIP3     = YW'(RECIP_WIDE);

    // calibration tracking: running sum plus two smallest and two largest
    logic [3:0]      r_calib_cnt;
    logic [SUMW-1:0] r_sum;
    logic [SB-1:0]   r_min1, r_min2, r_max1, r_max2;

    // divider operand
    logic [YW-1:0]   r_half;

    // scan state
    logic [SB-1:0]   r_baseline;
    logic [SB-1:0]   r_scan_max;
    logic [2:0]      r_scan_cnt;
    logic [1:0]      r_lockout;
    logic            r_kind;
    logic            r_press;

    // output register
    logic            r_out_valid;
    logic            r_out_kind;
    logic            r_out_press;
    logic [SB-1:0]   r_out_baseline;

    logic            calib_beat, scan_beat, calib_first;
    logic [SUMW-1:0] sum_base;
    logic [SB-1:0]   min1_b, min2_b, max1_b, max2_b;
    logic [2:0]      scan_next, group;
    logic            out_free;

    logic [2*YW-1:0] div_prod;
    logic [SUMW-1:0] lo_pair, hi_pair, mid_sum;

    logic [GW-1:0]   gate_lim;
    logic [TW-1:0]   ten_base;
    logic            scan_ok, lock_free;
    logic [1:0]      lock_eff;

    assign calib_beat  = i_cmd_ctl.accept && (i_cmd == CMD_CALIB);
    assign scan_beat   = i_cmd_ctl.accept && (i_cmd == CMD_SCAN);
    assign calib_first = (r_calib_cnt == 4'd0);

    // first sample of a batch starts from sentinels
    assign sum_base = calib_first ? '0 : r_sum;
    assign min1_b   = calib_first ? ONES : r_min1;
    assign min2_b   = calib_first ? ONES : r_min2;
    assign max1_b   = calib_first ? '0 : r_max1;
    assign max2_b   = calib_first ? '0 : r_max2;

    assign group     = i_continuous_mode ? SCAN_LONG : SCAN_SHORT;
    assign scan_next = r_scan_cnt + 3'd1;
    assign out_free  = !r_out_valid || !i_out_stall;

    // divide by six: halve, then multiply by the reciprocal of three
    assign div_prod = (2*YW)'(r_half) * (2*YW)'(RECIP3);

    // middle six = total minus two smallest and two largest
    assign lo_pair = SUMW'(r_min1) + SUMW'(r_min2);
    assign hi_pair = SUMW'(r_max1) + SUMW'(r_max2);
    assign mid_sum = r_sum - lo_pair - hi_pair;

    // scan judgment at full width
    assign gate_lim  = GW'(r_baseline) + GW'(i_gate_margin);
    assign ten_base  = (TW'(r_baseline) << 3) + (TW'(r_baseline) << 1);
    assign scan_ok   = (GW'(r_scan_max) > gate_lim) && (TW'(r_scan_max) < ten_base);
    assign lock_eff  = i_continuous_mode ? 2'd0 : r_lockout;
    assign lock_free = (lock_eff == 2'd0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_calib_cnt <= '0;
            r_baseline  <= '0;
            r_scan_cnt  <= '0;
            r_scan_max  <= '0;
            r_lockout   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (calib_beat) begin
                r_calib_cnt <= (r_calib_cnt >= CALIB_LAST) ? 4'd0 : r_calib_cnt + 4'd1;
            end
            if (scan_beat) begin
                if (r_scan_cnt == 3'd0 || i_sample > r_scan_max) begin
                    r_scan_max <= i_sample;
                end
                r_scan_cnt <= (scan_next >= group) ? 3'd0 : scan_next;
            end
            if (i_cmd_ctl.div_step) begin
                r_baseline <= div_prod[KW +: SB];
            end
            if (i_cmd_ctl.judge) begin
                r_lockout <= scan_ok ? LOCKOUT_RELOAD - 2'd1
                           : (lock_free ? 2'd0 : lock_eff - 2'd1);
            end
            if (i_cmd_ctl.emit && out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (calib_beat) begin
            r_sum <= sum_base + SUMW'(i_sample);
            if (i_sample < min1_b) begin
                r_min1 <= i_sample;
                r_min2 <= min1_b;
            end else begin
                r_min1 <= min1_b;
                r_min2 <= (i_sample < min2_b) ? i_sample : min2_b;
            end
            if (i_sample > max1_b) begin
                r_max1 <= i_sample;
                r_max2 <= max1_b;
            end else begin
                r_max1 <= max1_b;
                r_max2 <= (i_sample > max2_b) ? i_sample : max2_b;
            end
        end
        if (i_cmd_ctl.accept) begin
            r_kind  <= i_cmd;
            r_press <= 1'b0;
        end
        if (i_cmd_ctl.calc) begin
            r_half <= mid_sum[DW-1:1];
        end
        if (i_cmd_ctl.judge) begin
            r_press <= scan_ok && lock_free;
        end
        if (i_cmd_ctl.emit && out_free) begin
            r_out_kind     <= r_kind;
            r_out_press    <= r_press;
            r_out_baseline <= r_baseline;
        end
    end

    assign o_status.calib_last = (r_calib_cnt >= CALIB_LAST);
    assign o_status.scan_last  = (scan_next >= group);
    assign o_status.out_free   = out_free;

    assign o_out_valid = r_out_valid;
    assign o_kind      = r_out_kind;
    assign o_pressed   = r_out_press;
    assign o_baseline  = r_out_baseline;

endmodule

// ===== hw/rtl/touch_pad_press_detector_top.sv =====
// top level of the touch pad press detector
//
//  channel   direction  handshake                 payload
//  --------  ---------  ------------------------  ---------------------------------
//  in        input      i_in_valid / o_in_stall   i_cmd, i_sample
//  out       output     o_out_valid / i_out_stall o_kind, o_pressed, o_baseline
//  config    input      psel/penable/pwrite       paddr, pwdata, prdata, pready
//
// one beat is handled at a time; a sample that ends nothing is taken without a stall
// the tenth calibration sample steps through accept, halved middle sum,
// multiply by one third into the baseline, load result
// the last sample of a scan steps through accept, judge, load result
// a held result stalls the block only when a new result is ready behind it
// reset is synchronous, active low; all counters, baseline and lockout clear
module touch_pad_press_detector_top #(
    parameter int SAMPLE_BITS = 16
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // sample input
    input  logic                   i_in_valid,
    output logic                   o_in_stall,
    input  logic                   i_cmd,
    input  logic [SAMPLE_BITS-1:0] i_sample,
    // result output
    output logic                   o_out_valid,
    input  logic                   i_out_stall,
    output logic                   o_kind,
    output logic                   o_pressed,
    output logic [SAMPLE_BITS-1:0] o_baseline,
    // configuration port
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [2:0]             paddr,
    input  logic [31:0]            pwdata,
    output logic [31:0]            prdata,
    output logic                   pready
);
    import tpd_pkg::*;

    t_cmd        ctl_cmd;
    t_status     dp_status;
    logic [15:0] gate_margin;
    logic        continuous_mode;

    // register file: gate margin at 0x0, continuous mode at 0x4
    tpd_regs u_regs (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .psel              (psel),
        .penable           (penable),
        .pwrite            (pwrite),
        .paddr             (paddr),
        .pwdata            (pwdata),
        .prdata            (prdata),
        .pready            (pready),
        .o_gate_margin     (gate_margin),
        .o_continuous_mode (continuous_mode)
    );

    // sequencer: idle, baseline math, scan judgment, result hand-off
    tpd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_cmd      (i_cmd),
        .i_status   (dp_status),
        .o_in_stall (o_in_stall),
        .o_cmd      (ctl_cmd)
    );

    // datapath: calibration extremes and sum, divider, scan max, lockout
    tpd_datapath #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_datapath (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd_ctl         (ctl_cmd),
        .o_status          (dp_status),
        .i_cmd             (i_cmd),
        .i_sample          (i_sample),
        .i_gate_margin     (gate_margin),
        .i_continuous_mode (continuous_mode),
        .o_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .o_kind            (o_kind),
        .o_pressed         (o_pressed),
        .o_baseline        (o_baseline)
    );

endmodule
